### hw/rtl/plic_pkg.sv
// Shared types and constants of the platform interrupt controller.
// Used by the source cells, the top level and the port checker; no dependencies.
package plic_pkg;

    // Defaults of the top-level parameters
    localparam int NUM_SOURCES_DEF  = 32;
    localparam int NUM_CONTEXTS_DEF = 2;

    // Field widths
    localparam int SRC_ID_W   = 5;
    localparam int PRIO_W     = 3;
    localparam int CTX_ID_W   = 3;
    localparam int DATA_W     = 32;
    localparam int OFFSET_W   = 26;
    localparam int IRQ_W      = 2;
    localparam int REQ_W      = 2;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 40;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LEVEL = 2'd2;

    // Register map
    localparam logic [OFFSET_W-1:0] PRIO_END  = 26'h000_1000;
    localparam logic [OFFSET_W-1:0] PEND_OFF  = 26'h000_1000;
    localparam logic [OFFSET_W-1:0] EN_BASE   = 26'h000_2000;
    localparam int                  EN_SHIFT  = 7;
    localparam logic [OFFSET_W-1:0] CTX_BASE  = 26'h020_0000;
    localparam int                  CTX_SHIFT = 12;
    localparam logic [11:0]         REG_THRESH = 12'h000;
    localparam logic [11:0]         REG_CLAIM  = 12'h004;

    // Update broadcast to every source cell
    typedef struct packed {
        logic [SRC_ID_W-1:0] sel;
        logic                prio_we;
        logic [PRIO_W-1:0]   prio_val;
        logic                lvl_we;
        logic                lvl_val;
        logic                claim_set;
        logic                claim_clr;
        logic                en_we;
        logic [CTX_ID_W-1:0] en_ctx;
        logic [DATA_W-1:0]   en_val;
    } cell_cmd_t;

    // Search token handed from cell to cell during a claim
    typedef struct packed {
        logic                valid;
        logic [CTX_ID_W-1:0] ctx;
        logic [PRIO_W-1:0]   top;
        logic [SRC_ID_W-1:0] id;
    } scan_token_t;

endpackage

### hw/rtl/platform_interrupt_controller.sv
// A non-claim item passes through the EXEC and RESULT states into the output register; a
// claim read also passes through SCAN while the search token walks the source cell chain.
// One item at a time: the next item is accepted once this one has left RESULT for the
// output register; RESULT waits while a full output register is stalled.
// Reset (rst_n, asynchronous, active low) clears all priorities, levels, claims,
// enables and thresholds, and empties the output register.
module platform_interrupt_controller #(
    parameter int NUM_SOURCES  = plic_pkg::NUM_SOURCES_DEF,
    parameter int NUM_CONTEXTS = plic_pkg::NUM_CONTEXTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // offset, write_data, source_id, source_level
    input  logic [plic_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [plic_pkg::REQ_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_data, irq_lines, zero pad
    output logic [plic_pkg::M_TDATA_W-1:0] m_tdata
);
    import plic_pkg::*;

    localparam int SIW = $clog2(NUM_SOURCES);
    localparam int CIW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_RESULT} state_t;

    state_t                 state_reg;
    logic [REQ_W-1:0]       req_type_reg;
    logic [OFFSET_W-1:0]    offset_reg;
    logic [DATA_W-1:0]      write_data_reg;
    logic [SRC_ID_W-1:0]    source_id_reg;
    logic                   source_level_reg;
    logic [DATA_W-1:0]      rd_reg;
    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_data_reg;
    logic [PRIO_W-1:0]      thr_reg [NUM_CONTEXTS];

    cell_cmd_t              cmd;
    scan_token_t            tok [NUM_SOURCES+1];
    logic [PRIO_W-1:0]      prio_arr [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] pend_vec;
    logic [NUM_CONTEXTS-1:0] en_arr [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] en_col [NUM_CONTEXTS];
    logic [NUM_CONTEXTS-1:0] irq_vec;
    logic [IRQ_W-1:0]       irq_out;

    logic [9:0]             prio_idx;
    logic                   prio_ok;
    logic                   pend_hit;
    logic [18:0]            en_blk;
    logic                   en_hit;
    logic [13:0]            ctx_blk;
    logic                   ctx_ok;
    logic                   thr_hit;
    logic                   claim_hit;
    logic                   scan_start;
    logic [DATA_W-1:0]      rd_exec;

    // Source cell chain
    assign tok[0].valid = scan_start;
    assign tok[0].ctx   = ctx_blk[CTX_ID_W-1:0];
    assign tok[0].top   = thr_reg[ctx_blk[CIW-1:0]];
    assign tok[0].id    = '0;

    for (genvar s = 0; s < NUM_SOURCES; s++)
    begin : g_cell
        plic_cell #(
            .IDX          (s),
            .NUM_CONTEXTS (NUM_CONTEXTS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .tok_in  (tok[s]),
            .tok_out (tok[s+1]),
            .prio    (prio_arr[s]),
            .pend    (pend_vec[s]),
            .en      (en_arr[s])
        );
    end

    // Gather enable columns and request lines per context
    always_comb
    begin
        for (int c = 0; c < NUM_CONTEXTS; c++)
        begin
            for (int s = 0; s < NUM_SOURCES; s++)
            begin
                en_col[c][s] = en_arr[s][c];
            end
        end
        for (int c = 0; c < NUM_CONTEXTS; c++)
        begin
            irq_vec[c] = 1'b0;
            for (int s = 0; s < NUM_SOURCES; s++)
            begin
                irq_vec[c] = irq_vec[c] |
                    (pend_vec[s] & en_arr[s][c] & (prio_arr[s] > thr_reg[c]));
            end
        end
        for (int i = 0; i < IRQ_W; i++)
        begin
            irq_out[i] = (i < NUM_CONTEXTS) ? irq_vec[i] : 1'b0;
        end
    end

    // Decode the offset of the held item
    always_comb
    begin
        prio_idx  = offset_reg[11:2];
        prio_ok   = (offset_reg < PRIO_END) && (prio_idx < 10'(NUM_SOURCES));
        pend_hit  = (offset_reg == PEND_OFF);
        en_blk    = offset_reg[OFFSET_W-1:EN_SHIFT] - 19'(EN_BASE >> EN_SHIFT);
        en_hit    = (offset_reg >= EN_BASE) && (en_blk < 19'(NUM_CONTEXTS)) &&
                    (offset_reg[EN_SHIFT-1:0] == '0);
        ctx_blk   = offset_reg[OFFSET_W-1:CTX_SHIFT] - 14'(CTX_BASE >> CTX_SHIFT);
        ctx_ok    = (offset_reg >= CTX_BASE) && (ctx_blk < 14'(NUM_CONTEXTS));
        thr_hit   = ctx_ok && (offset_reg[CTX_SHIFT-1:0] == REG_THRESH);
        claim_hit = ctx_ok && (offset_reg[CTX_SHIFT-1:0] == REG_CLAIM);
        scan_start = (state_reg == ST_EXEC) && (req_type_reg == REQ_READ) && claim_hit;
    end

    // Select bus read data for plain registers
    always_comb
    begin
        rd_exec = '0;
        if (prio_ok)
        begin
            rd_exec = DATA_W'(prio_arr[prio_idx[SIW-1:0]]);
        end
        else if (pend_hit)
        begin
            rd_exec = DATA_W'(pend_vec);
        end
        else if (en_hit)
        begin
            rd_exec = DATA_W'(en_col[en_blk[CIW-1:0]]);
        end
        else if (thr_hit)
        begin
            rd_exec = DATA_W'(thr_reg[ctx_blk[CIW-1:0]]);
        end
    end

    // Build the cell update for this cycle
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_EXEC:
            begin
                if (req_type_reg == REQ_WRITE)
                begin
                    if (prio_ok && (prio_idx != '0))
                    begin
                        cmd.sel      = prio_idx[SRC_ID_W-1:0];
                        cmd.prio_we  = 1'b1;
                        cmd.prio_val = write_data_reg[PRIO_W-1:0];
                    end
                    if (en_hit)
                    begin
                        cmd.en_we  = 1'b1;
                        cmd.en_ctx = en_blk[CTX_ID_W-1:0];
                        cmd.en_val = write_data_reg;
                    end
                    if (claim_hit && (write_data_reg != '0) &&
                        (write_data_reg < DATA_W'(NUM_SOURCES)))
                    begin
                        cmd.sel       = write_data_reg[SRC_ID_W-1:0];
                        cmd.claim_clr = 1'b1;
                    end
                end
                else if (req_type_reg == REQ_LEVEL)
                begin
                    if ((source_id_reg != '0) &&
                        ({1'b0, source_id_reg} < 6'(NUM_SOURCES)))
                    begin
                        cmd.sel     = source_id_reg;
                        cmd.lvl_we  = 1'b1;
                        cmd.lvl_val = source_level_reg;
                    end
                end
            end
            ST_SCAN:
            begin
                if (tok[NUM_SOURCES].valid && (tok[NUM_SOURCES].id != '0))
                begin
                    cmd.sel       = tok[NUM_SOURCES].id;
                    cmd.claim_set = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Hold control state, thresholds and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            req_type_reg     <= '0;
            offset_reg       <= '0;
            write_data_reg   <= '0;
            source_id_reg    <= '0;
            source_level_reg <= 1'b0;
            rd_reg           <= '0;
            m_valid_reg      <= 1'b0;
            m_data_reg       <= '0;
            for (int c = 0; c < NUM_CONTEXTS; c++)
            begin
                thr_reg[c] <= '0;
            end
        end
        else
        begin
            if (m_valid_reg && m_tready && (state_reg != ST_RESULT))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        req_type_reg     <= s_tuser;
                        offset_reg       <= s_tdata[25:0];
                        write_data_reg   <= s_tdata[57:26];
                        source_id_reg    <= s_tdata[62:58];
                        source_level_reg <= s_tdata[63];
                        state_reg        <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    rd_reg <= (req_type_reg == REQ_READ) ? rd_exec : '0;
                    if ((req_type_reg == REQ_WRITE) && thr_hit)
                    begin
                        thr_reg[ctx_blk[CIW-1:0]] <= write_data_reg[PRIO_W-1:0];
                    end
                    state_reg <= scan_start ? ST_SCAN : ST_RESULT;
                end
                ST_SCAN:
                begin
                    if (tok[NUM_SOURCES].valid)
                    begin
                        rd_reg    <= DATA_W'(tok[NUM_SOURCES].id);
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {{(M_TDATA_W-DATA_W-IRQ_W){1'b0}}, irq_out, rd_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### hw/rtl/plic_cell.sv
// One interrupt source cell: priority, line level, claim bit and enables.
// Passes the claim search token to its neighbor each cycle; uses plic_pkg.
module plic_cell #(
    parameter int IDX          = 0,
    parameter int NUM_CONTEXTS = plic_pkg::NUM_CONTEXTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  plic_pkg::cell_cmd_t         cmd,
    input  plic_pkg::scan_token_t       tok_in,
    output plic_pkg::scan_token_t       tok_out,
    output logic [plic_pkg::PRIO_W-1:0] prio,
    output logic                        pend,
    output logic [NUM_CONTEXTS-1:0]     en
);
    import plic_pkg::*;

    localparam int CIW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam logic LIVE = (IDX != 0);
    localparam logic [SRC_ID_W-1:0] MY_ID = SRC_ID_W'(IDX);

    logic [PRIO_W-1:0]       prio_reg, prio_next;
    logic                    lvl_reg, lvl_next;
    logic                    claimed_reg, claimed_next;
    logic [NUM_CONTEXTS-1:0] en_reg, en_next;
    scan_token_t             tok_reg, tok_next;
    logic                    hit;
    logic                    eligible;

    // Apply broadcast updates addressed to this source
    always_comb
    begin
        hit          = LIVE && (cmd.sel == MY_ID);
        prio_next    = prio_reg;
        lvl_next     = lvl_reg;
        claimed_next = claimed_reg;
        en_next      = en_reg;
        if (hit && cmd.prio_we)
        begin
            prio_next = cmd.prio_val;
        end
        if (hit && cmd.lvl_we)
        begin
            lvl_next = cmd.lvl_val;
        end
        if (hit && cmd.claim_set)
        begin
            claimed_next = 1'b1;
        end
        if (hit && cmd.claim_clr)
        begin
            claimed_next = 1'b0;
        end
        if (LIVE && cmd.en_we)
        begin
            en_next[cmd.en_ctx[CIW-1:0]] = cmd.en_val[IDX];
        end
    end

    // Take over the token when this source beats the best so far
    always_comb
    begin
        eligible = lvl_reg && !claimed_reg && en_reg[tok_in.ctx[CIW-1:0]];
        tok_next = tok_in;
        if (tok_in.valid && eligible && (prio_reg > tok_in.top))
        begin
            tok_next.top = prio_reg;
            tok_next.id  = MY_ID;
        end
    end

    // Hold cell state and advance the token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg    <= '0;
            lvl_reg     <= 1'b0;
            claimed_reg <= 1'b0;
            en_reg      <= '0;
            tok_reg     <= '0;
        end
        else
        begin
            prio_reg    <= prio_next;
            lvl_reg     <= lvl_next;
            claimed_reg <= claimed_next;
            en_reg      <= en_next;
            tok_reg     <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign prio    = prio_reg;
    assign pend    = lvl_reg && !claimed_reg;
    assign en      = en_reg;

endmodule

### hw/rtl/plic_checker.sv
// Port-level checks of the platform interrupt controller, bound to the top level.
// Uses plic_pkg for request kinds and widths.
module plic_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [plic_pkg::REQ_W-1:0]     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [plic_pkg::M_TDATA_W-1:0] m_tdata
);
    import plic_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: input closes right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is at work");

    // Non-read item with an empty output gives a zero read word once it has passed EXEC and RESULT
    a_nonread_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != REQ_READ) && !m_tvalid
        |-> ##3 (m_tvalid && (m_tdata[DATA_W-1:0] == '0)))
        else $error("non-read item result missing or nonzero");

endmodule

bind platform_interrupt_controller plic_checker u_plic_checker (.*);
